@@ rtl/lchc_pkg.sv @@
// Shared types and constants for the long contact hit classifier.
package lchc_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned HOLD_W   = 24;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd3000000;

  // bit 0 valid left, bit 1 valid right, bit 2 invalid left, bit 3 invalid right
  typedef logic [CHANNELS-1:0] chan_mask_t;

  typedef struct packed {
    chan_mask_t raw;
    chan_mask_t fired;
  } chan_status_t;

  typedef struct packed {
    logic       valid;
    chan_mask_t mask;
    logic       dbl;
  } hit_event_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_WAIT   = 3'b010,
    PH_SINGLE = 3'b100
  } phase_t;

endpackage

@@ rtl/lchc_channel.sv @@
// Per-channel hold counter and re-arm latch.
module lchc_channel import lchc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned NEED_W     = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [NEED_W-1:0] need,
  output logic              fire
);

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  latch;
  logic                  latch_next;
  logic                  gated;

  always_comb begin
    gated      = level && !latch;
    cnt_inc    = (&cnt) ? cnt : cnt + COUNT_BITS'(1);
    fire       = gated && (NEED_W'(cnt_inc) >= need);
    cnt_next   = gated ? cnt_inc : '0;
    latch_next = level && (latch || fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      latch <= 1'b0;
    end else if (step) begin
      cnt   <= cnt_next;
      latch <= latch_next;
    end
  end

  a_fire_sets_latch: assert property (@(posedge clk) disable iff (rst)
    step && fire |=> latch)
    else $error("channel fired without latching");

endmodule

@@ rtl/lchc_fsm.sv @@
// Phase machine turning channel firings into hit events.
module lchc_fsm import lchc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  chan_status_t status,
  output hit_event_t   ev
);

  phase_t     phase;
  phase_t     phase_next;
  chan_mask_t first_mask;
  chan_mask_t first_mask_next;
  logic       multi;

  always_comb begin
    phase_next      = phase;
    first_mask_next = first_mask;
    ev              = '0;
    multi           = (status.fired & (status.fired - chan_mask_t'(1))) != '0;
    unique case (phase)
      PH_WAIT: begin
        if (status.fired != '0) begin
          phase_next = PH_IDLE;
          ev = '{valid: 1'b1, mask: first_mask | status.fired, dbl: 1'b1};
        end else if ((status.raw & ~first_mask) == '0) begin
          phase_next = PH_SINGLE;
          ev = '{valid: 1'b1, mask: first_mask, dbl: 1'b0};
        end
      end
      PH_SINGLE: begin
        if (status.fired != '0) begin
          phase_next = PH_IDLE;
          ev = '{valid: 1'b1, mask: first_mask | status.fired, dbl: 1'b1};
        end else if (status.raw == '0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (status.fired != '0) begin
          if (multi) begin
            ev = '{valid: 1'b1, mask: status.fired, dbl: 1'b1};
          end else begin
            first_mask_next = status.fired;
            if ((status.raw & ~status.fired) == '0) begin
              phase_next = PH_SINGLE;
              ev = '{valid: 1'b1, mask: status.fired, dbl: 1'b0};
            end else begin
              phase_next = PH_WAIT;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      first_mask <= '0;
    end else if (step) begin
      phase      <= phase_next;
      first_mask <= first_mask_next;
    end
  end

  a_wait_one_first: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WAIT |-> $onehot(first_mask))
    else $error("waiting with other than one first channel");

  a_single_one_flag: assert property (@(posedge clk) disable iff (rst)
    step && ev.valid && !ev.dbl |-> $onehot(ev.mask))
    else $error("single event with other than one channel");

endmodule

@@ rtl/long_contact_hit_classifier.sv @@
// Top level of the long contact hit classifier.
//
// Input stream: one item per sample tick of the four contact lines, taken on
// s_axis_tvalid & s_axis_tready. Each channel counts ticks of continuous
// contact and fires once when the count reaches hold_ticks; firings become
// hit events (single or double) on the output stream.
// Output stream: at most one event item per input item, valid in the cycle after
// the input item is taken. Throughput is one item per cycle; the result
// register is the only stage, so s_axis_tready drops only while an event
// waits in it and m_axis_tready is low.
// Ticks that produce no event leave the output idle.
// cfg_we writes hold_ticks (24 bits); write only while the stream is idle.
// Reset: hold_ticks = 3000000, counters and latches cleared, phase idle,
// output empty.
module long_contact_hit_classifier import lchc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // valid left, valid right, invalid left, invalid right
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // hit_valid_left, hit_valid_right, hit_invalid_left,
                                           // hit_invalid_right, is_double
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata
);

  localparam int unsigned NEED_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

  logic [HOLD_W-1:0] hold_ticks;
  logic [NEED_W-1:0] need;
  logic              step;
  chan_status_t      status;
  hit_event_t        ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  assign need = (hold_ticks == '0) ? NEED_W'(1) : NEED_W'(hold_ticks);

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign status.raw    = s_axis_tdata[CHANNELS-1:0];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    lchc_channel #(
      .COUNT_BITS(COUNT_BITS),
      .NEED_W    (NEED_W)
    ) u_chan (
      .clk  (clk),
      .rst  (rst),
      .step (step),
      .level(s_axis_tdata[i]),
      .need (need),
      .fire (status.fired[i])
    );
  end

  lchc_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .status(status),
    .ev    (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= step && ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      m_axis_tdata <= {3'b000, ev.dbl, ev.mask};
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

@@ bench/tb_long_contact_hit_classifier.sv @@
// Self-checking testbench for the long contact hit classifier stream block.
`timescale 1ns / 1ps

module tb_long_contact_hit_classifier import lchc_pkg::*;;

  localparam int unsigned CNT_W       = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // valid left, valid right, invalid left, invalid right
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // hit_valid_left, hit_valid_right, hit_invalid_left,
                                          // hit_invalid_right, is_double
  logic              cfg_we = 1'b0;
  logic [HOLD_W-1:0] cfg_wdata = '0;

  long_contact_hit_classifier #(.COUNT_BITS(CNT_W)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // classifier state as predicted
  logic [HOLD_W-1:0] hold_len;
  logic [CNT_W-1:0]  run_len [CHANNELS];
  logic              rearm   [CHANNELS];
  phase_t            ph;
  chan_mask_t        lead_mask;
  hit_event_t        hits_due [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          src_calm    = 1'b0;
  bit          sink_calm   = 1'b0;
  int unsigned sink_hold_req = 0;
  int unsigned sink_stall    = 0;

  // random contact pattern generator
  chan_mask_t  gen_lvl = '0;
  int unsigned gen_left [CHANNELS];

  task automatic reset_model();
    hold_len  = HOLD_RESET;
    ph        = PH_IDLE;
    lead_mask = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      run_len[c]  = '0;
      rearm[c]    = 1'b0;
      gen_left[c] = 0;
    end
  endtask

  task automatic classify_tick(input chan_mask_t lvl);
    chan_mask_t       fired;
    int unsigned      nfired;
    logic [CNT_W-1:0] need;
    fired  = '0;
    nfired = 0;
    need   = (hold_len == 0) ? CNT_W'(1) : CNT_W'(hold_len);
    for (int c = 0; c < CHANNELS; c++) begin
      if (!lvl[c]) rearm[c] = 1'b0;
      if (lvl[c] && !rearm[c]) begin
        if (run_len[c] != '1) run_len[c]++;
        if (run_len[c] >= need) begin
          fired[c] = 1'b1;
          rearm[c] = 1'b1;
          nfired++;
        end
      end else begin
        run_len[c] = '0;
      end
    end
    case (ph)
      PH_WAIT: begin
        if (fired != 0) begin
          ph = PH_IDLE;
          hits_due.push_back({1'b1, lead_mask | fired, 1'b1});
        end else if ((lvl & ~lead_mask) == 0) begin
          ph = PH_SINGLE;
          hits_due.push_back({1'b1, lead_mask, 1'b0});
        end
      end
      PH_SINGLE: begin
        if (fired != 0) begin
          ph = PH_IDLE;
          hits_due.push_back({1'b1, lead_mask | fired, 1'b1});
        end else if (lvl == 0) begin
          ph = PH_IDLE;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (fired != 0) begin
          if (nfired >= 2) begin
            hits_due.push_back({1'b1, fired, 1'b1});
          end else begin
            lead_mask = fired;
            if ((lvl & ~fired) == 0) begin
              ph = PH_SINGLE;
              hits_due.push_back({1'b1, fired, 1'b0});
            end else begin
              ph = PH_WAIT;
            end
          end
        end
      end
    endcase
  endtask

  function automatic string field_name(input int b);
    case (b)
      0:       return "hit_valid_left";
      1:       return "hit_valid_right";
      2:       return "hit_invalid_left";
      3:       return "hit_invalid_right";
      default: return "is_double";
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    hit_event_t want;
    logic [4:0] want_bits;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hits_due.size() == 0) begin
        $error("unexpected event item, tdata %02h", m_axis_tdata);
        mismatches++;
      end else begin
        want      = hits_due.pop_front();
        want_bits = {want.dbl, want.mask};
        for (int b = 0; b < 5; b++) begin
          if (m_axis_tdata[b] !== want_bits[b]) begin
            $error("%s: expected %0b, got %0b", field_name(b), want_bits[b], m_axis_tdata[b]);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: short random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (sink_hold_req != 0) begin
      sink_stall    = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_tick(input chan_mask_t lvl);
    int unsigned gap;
    if (!src_calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, lvl};
    do @(posedge clk); while (!s_axis_tready);
    classify_tick(lvl);
  endtask

  task automatic src_stop();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (hits_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_hold(input logic [HOLD_W-1:0] v);
    src_stop();
    wait_drained();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    hold_len = v;
  endtask

  task automatic run_random(input int unsigned n_items);
    chan_mask_t  lvl;
    chan_mask_t  active;
    int unsigned seg_left;
    int unsigned h;
    seg_left = 0;
    active   = '1;
    h = (hold_len == 0) ? 1 : ((hold_len > 6) ? 6 : int'(hold_len));
    repeat (n_items) begin
      if (seg_left == 0) begin
        active   = chan_mask_t'($urandom_range(1, 15));
        seg_left = $urandom_range(15, 50);
      end
      seg_left--;
      for (int c = 0; c < CHANNELS; c++) begin
        if (gen_left[c] == 0) begin
          gen_lvl[c]  = ~gen_lvl[c] & active[c];
          gen_left[c] = gen_lvl[c] ? $urandom_range(1, 2 * h + 2) : $urandom_range(1, h + 2);
        end
        gen_left[c]--;
      end
      lvl = gen_lvl;
      if ($urandom_range(0, 11) == 0) lvl = chan_mask_t'($urandom_range(0, 15));
      push_tick(lvl);
    end
  endtask

  // default hold time is far out of reach: nothing may fire
  task automatic test_reset_hold();
    repeat (3) push_tick(4'b1111);
    push_tick(4'b0000);
  endtask

  task automatic test_directed_cases();
    set_hold(2);
    // lone single, then release
    push_tick(4'b0001); push_tick(4'b0001); push_tick(4'b0000);
    // simultaneous double
    push_tick(4'b0011); push_tick(4'b0011); push_tick(4'b0000);
    // first fires while other pressing, other then fires
    push_tick(4'b0001); push_tick(4'b1001); push_tick(4'b1000); push_tick(4'b0000);
    // waiting single released once other side lets go
    push_tick(4'b0001); push_tick(4'b0011); push_tick(4'b0001); push_tick(4'b0000);
    // single emitted, long hold fires once, late second side makes a double
    push_tick(4'b0010); push_tick(4'b0010); push_tick(4'b0110); push_tick(4'b0110);
    push_tick(4'b0000);
    // all four at once
    push_tick(4'b1111); push_tick(4'b1111); push_tick(4'b0000);
    // zero hold time behaves as one tick
    set_hold(0);
    push_tick(4'b0010); push_tick(4'b0000);
  endtask

  task automatic test_random_sweep();
    set_hold(1);
    run_random(160);
    set_hold(3);
    run_random(160);
    set_hold(0);
    run_random(150);
    set_hold(HOLD_MAX);
    run_random(40);
    set_hold(5);
    run_random(160);
    set_hold(HOLD_W'($urandom_range(1, 8)));
    run_random(150);
  endtask

  task automatic test_backpressure();
    set_hold(2);
    run_random(60);
    sink_hold_req = 60;
    run_random(60);
    src_stop();
    wait_drained();
    run_random(60);
  endtask

  task automatic test_calm_tail();
    set_hold(4);
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    run_random(150);
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_hold();
    test_directed_cases();
    test_random_sweep();
    test_backpressure();
    test_calm_tail();

    src_stop();
    wait_drained();
    repeat (5) @(posedge clk);
    if (hits_due.size() != 0) begin
      $error("%0d expected events never arrived", hits_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lchc_pkg.sv
rtl/lchc_channel.sv
rtl/lchc_fsm.sv
rtl/long_contact_hit_classifier.sv
bench/tb_long_contact_hit_classifier.sv
